FILE: design/utf8v_pkg.sv
`timescale 1ns / 1ps
// Package for the UTF-8 text validator: verdict codes, register indexes,
// code point limits and the running state and configuration structs.
package utf8v_pkg;

  localparam int unsigned CapW  = 16;
  localparam int unsigned CpW   = 21;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    VERDICT_PENDING = 2'd0,
    VERDICT_VALID   = 2'd1,
    VERDICT_INVALID = 2'd2
  } verdict_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEXT_CAPACITY    = 2'd0,
    REG_REQUIRE_NONEMPTY = 2'd1,
    REG_IDENTIFIER_MODE  = 2'd2
  } reg_idx_e;

  localparam logic [CapW-1:0] CapacityReset = 16'd64;
  localparam logic [CapW-1:0] BytesMax      = 16'hffff;

  localparam logic [7:0] Lead2Lo   = 8'hc2;
  localparam logic [7:0] Lead2Hi   = 8'hdf;
  localparam logic [7:0] Lead3Lo   = 8'he0;
  localparam logic [7:0] Lead3Hi   = 8'hef;
  localparam logic [7:0] Lead4Lo   = 8'hf0;
  localparam logic [7:0] Lead4Hi   = 8'hf4;
  localparam logic [7:0] CtrlLimit = 8'd32;
  localparam logic [7:0] DelByte   = 8'd127;

  localparam logic [CpW-1:0] CpMax    = 21'h10ffff;
  localparam logic [CpW-1:0] SurLo    = 21'h00d800;
  localparam logic [CpW-1:0] SurHi    = 21'h00dfff;
  localparam logic [CpW-1:0] Min2Byte = 21'h000080;
  localparam logic [CpW-1:0] Min3Byte = 21'h000800;
  localparam logic [CpW-1:0] Min4Byte = 21'h010000;

  typedef struct packed {
    logic [CapW-1:0] capacity;
    logic            require_nonempty;
    logic            identifier_mode;
  } cfg_t;

  typedef struct packed {
    logic [CapW-1:0] bytes_taken;
    logic [1:0]      cont_left;
    logic [CpW-1:0]  cp_acc;
    logic [1:0]      len_class;
    logic            reached;
  } state_t;

endpackage

FILE: design/utf8v_judge.sv
`timescale 1ns / 1ps
// Per-byte decode step of the UTF-8 text validator: next running state and verdict.
// Depends on utf8v_pkg.
module utf8v_judge (
  input  utf8v_pkg::state_t   st_i,
  input  utf8v_pkg::cfg_t     cfg_i,
  input  logic [7:0]          text_byte_i,
  input  logic                starts_text_i,
  output utf8v_pkg::state_t   st_o,
  output utf8v_pkg::verdict_e verdict_o
);

  always_comb begin
    utf8v_pkg::state_t          s;
    utf8v_pkg::state_t          nxt;
    utf8v_pkg::verdict_e        v;
    logic [utf8v_pkg::CpW-1:0]  acc;
    logic [utf8v_pkg::CpW-1:0]  min_cp;
    logic [utf8v_pkg::CapW-1:0] bytes_inc;
    logic                       id_ok;

    s = st_i;
    if (starts_text_i) begin
      s = '0;
    end
    nxt       = s;
    v         = utf8v_pkg::VERDICT_PENDING;
    acc       = {s.cp_acc[utf8v_pkg::CpW-7:0], text_byte_i[5:0]};
    min_cp    = utf8v_pkg::Min4Byte;
    bytes_inc = s.bytes_taken;
    id_ok     = text_byte_i inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39],
                                    8'h2d, 8'h5f, 8'h2e, 8'h3a, 8'h2f};

    if (!s.reached) begin
      if (cfg_i.capacity == '0) begin
        v = utf8v_pkg::VERDICT_INVALID;
      end else begin
        if (s.cont_left != 2'd0) begin
          if (text_byte_i[7:6] != 2'b10) begin
            v = utf8v_pkg::VERDICT_INVALID;
          end else begin
            nxt.cp_acc    = acc;
            nxt.cont_left = s.cont_left - 2'd1;
            if (s.cont_left == 2'd1) begin
              case (s.len_class)
                2'd1:    min_cp = utf8v_pkg::Min2Byte;
                2'd2:    min_cp = utf8v_pkg::Min3Byte;
                default: min_cp = utf8v_pkg::Min4Byte;
              endcase
              if (acc < min_cp || acc > utf8v_pkg::CpMax ||
                  (acc >= utf8v_pkg::SurLo && acc <= utf8v_pkg::SurHi)) begin
                v = utf8v_pkg::VERDICT_INVALID;
              end
            end
          end
        end else if (text_byte_i == 8'd0) begin
          if (s.bytes_taken == '0 && cfg_i.require_nonempty) begin
            v = utf8v_pkg::VERDICT_INVALID;
          end else begin
            v = utf8v_pkg::VERDICT_VALID;
          end
        end else if (text_byte_i < utf8v_pkg::CtrlLimit ||
                     text_byte_i == utf8v_pkg::DelByte) begin
          v = utf8v_pkg::VERDICT_INVALID;
        end else if (!text_byte_i[7]) begin
          if (cfg_i.identifier_mode && !id_ok) begin
            v = utf8v_pkg::VERDICT_INVALID;
          end
        end else if (cfg_i.identifier_mode) begin
          v = utf8v_pkg::VERDICT_INVALID;
        end else if (text_byte_i inside {[utf8v_pkg::Lead2Lo:utf8v_pkg::Lead2Hi]}) begin
          nxt.len_class = 2'd1;
          nxt.cont_left = 2'd1;
          nxt.cp_acc    = {16'd0, text_byte_i[4:0]};
        end else if (text_byte_i inside {[utf8v_pkg::Lead3Lo:utf8v_pkg::Lead3Hi]}) begin
          nxt.len_class = 2'd2;
          nxt.cont_left = 2'd2;
          nxt.cp_acc    = {17'd0, text_byte_i[3:0]};
        end else if (text_byte_i inside {[utf8v_pkg::Lead4Lo:utf8v_pkg::Lead4Hi]}) begin
          nxt.len_class = 2'd3;
          nxt.cont_left = 2'd3;
          nxt.cp_acc    = {18'd0, text_byte_i[2:0]};
        end else begin
          v = utf8v_pkg::VERDICT_INVALID;
        end

        if (s.bytes_taken != utf8v_pkg::BytesMax) begin
          bytes_inc = s.bytes_taken + 16'd1;
        end
        nxt.bytes_taken = bytes_inc;
        if (v == utf8v_pkg::VERDICT_PENDING && bytes_inc >= cfg_i.capacity) begin
          v = utf8v_pkg::VERDICT_INVALID;
        end
      end
      if (v != utf8v_pkg::VERDICT_PENDING) begin
        nxt.reached = 1'b1;
      end
    end

    st_o      = nxt;
    verdict_o = v;
  end

endmodule

FILE: design/utf8_text_validator.sv
`timescale 1ns / 1ps
// UTF-8 text validator top level: config registers, running state, result register.
// Depends on utf8v_pkg and utf8v_judge.
// The result of an accepted byte is registered in the output register.
// Throughput: one byte per cycle; the result register stalls input only while full
// and stalled downstream.
// Reset: asynchronous, active low; capacity 64, text required, identifier mode off,
// idle until a byte with starts_text set arrives.
module utf8_text_validator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        starts_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  verdict_o,
  output logic        decided_o
);

  utf8v_pkg::cfg_t     cfg_q;
  utf8v_pkg::state_t   st_q, st_d;
  utf8v_pkg::verdict_e verdict_d;
  logic [1:0]          verdict_q;
  logic                decided_q;
  logic                out_valid_q, out_valid_d;
  logic                in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_d = in_acc | (out_valid_q & out_stall_i);

  utf8v_judge u_judge (
    .st_i          (st_q),
    .cfg_i         (cfg_q),
    .text_byte_i   (text_byte_i),
    .starts_text_i (starts_text_i),
    .st_o          (st_d),
    .verdict_o     (verdict_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capacity         <= utf8v_pkg::CapacityReset;
      cfg_q.require_nonempty <= 1'b1;
      cfg_q.identifier_mode  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        utf8v_pkg::REG_TEXT_CAPACITY:    cfg_q.capacity         <= cfg_data_i;
        utf8v_pkg::REG_REQUIRE_NONEMPTY: cfg_q.require_nonempty <= cfg_data_i[0];
        utf8v_pkg::REG_IDENTIFIER_MODE:  cfg_q.identifier_mode  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= '0;
      st_q.reached <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      verdict_q <= verdict_d;
      decided_q <= (verdict_d != utf8v_pkg::VERDICT_PENDING);
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;
  assign decided_o   = decided_q;

  a_decided_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (decided_o == (verdict_o != utf8v_pkg::VERDICT_PENDING)))
    else $error("decided flag disagrees with verdict");

  a_ignored_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && st_q.reached && !starts_text_i) |=>
      (out_valid_o && verdict_o == utf8v_pkg::VERDICT_PENDING && !decided_o))
    else $error("byte after decision was not ignored");

  a_no_cont_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.bytes_taken == '0) |-> (st_q.cont_left == 2'd0))
    else $error("continuations due before any byte taken");

  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with empty result register");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for utf8_text_validator: streams texts, mostly NUL-terminated,
// under random gaps and stalls, predicts each verdict and checks every result.
// Depends on utf8v_pkg and the validator RTL.
module tb;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned MaxShown      = 40;
  localparam logic [1:0]  RegUnused     = 2'd3;
  localparam logic [7:0]  ContMark      = 8'h80;
  localparam logic [7:0]  Lead2Mark     = 8'hc0;
  localparam logic [7:0]  NulByte       = 8'h00;

  typedef struct {
    logic [7:0] data;
    logic       start;
    bit         hold;
  } text_item_t;

  typedef struct {
    utf8v_pkg::verdict_e verdict;
    logic                decided;
  } verdict_rec_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = 2'd0;
  logic [15:0] cfg_data_i    = 16'd0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [7:0]  text_byte_i   = 8'd0;
  logic        starts_text_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [1:0]  verdict_o;
  logic        decided_o;

  text_item_t        byte_feed[$];
  verdict_rec_t      due_verdicts[$];
  utf8v_pkg::cfg_t   model_cfg;
  utf8v_pkg::state_t model_st;

  int unsigned fed_total    = 0;
  int unsigned bytes_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned gap_left     = 0;
  int unsigned burst_left   = 1;
  int unsigned mode_left    = 0;
  int unsigned stall_tick   = 0;
  stall_mode_e stall_mode   = STALL_NONE;
  bit          bursty       = 1'b0;
  string       id_chars     =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_.:/";

  utf8_text_validator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .text_byte_i   (text_byte_i),
    .starts_text_i (starts_text_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .verdict_o     (verdict_o),
    .decided_o     (decided_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Verdict that one byte settles, advancing the sequence decoder.
  function automatic utf8v_pkg::verdict_e judge_byte(logic [7:0] b, bit first);
    logic [utf8v_pkg::CpW-1:0] floor_cp;
    if (model_st.cont_left != 2'd0) begin
      if (b[7:6] != 2'b10) return utf8v_pkg::VERDICT_INVALID;
      model_st.cp_acc    = {model_st.cp_acc[utf8v_pkg::CpW-7:0], b[5:0]};
      model_st.cont_left = model_st.cont_left - 2'd1;
      if (model_st.cont_left != 2'd0) return utf8v_pkg::VERDICT_PENDING;
      case (model_st.len_class)
        2'd1:    floor_cp = utf8v_pkg::Min2Byte;
        2'd2:    floor_cp = utf8v_pkg::Min3Byte;
        default: floor_cp = utf8v_pkg::Min4Byte;
      endcase
      if (model_st.cp_acc < floor_cp || model_st.cp_acc > utf8v_pkg::CpMax ||
          (model_st.cp_acc >= utf8v_pkg::SurLo && model_st.cp_acc <= utf8v_pkg::SurHi))
        return utf8v_pkg::VERDICT_INVALID;
      return utf8v_pkg::VERDICT_PENDING;
    end
    if (b == NulByte)
      return (first && model_cfg.require_nonempty) ? utf8v_pkg::VERDICT_INVALID
                                                   : utf8v_pkg::VERDICT_VALID;
    if (b < utf8v_pkg::CtrlLimit || b == utf8v_pkg::DelByte)
      return utf8v_pkg::VERDICT_INVALID;
    if (!b[7]) begin
      if (model_cfg.identifier_mode &&
          !((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b >= "0" && b <= "9") ||
            b == "-" || b == "_" || b == "." || b == ":" || b == "/"))
        return utf8v_pkg::VERDICT_INVALID;
      return utf8v_pkg::VERDICT_PENDING;
    end
    if (model_cfg.identifier_mode) return utf8v_pkg::VERDICT_INVALID;
    if (b >= utf8v_pkg::Lead2Lo && b <= utf8v_pkg::Lead2Hi) begin
      model_st.len_class = 2'd1;
      model_st.cp_acc    = utf8v_pkg::CpW'(b[4:0]);
    end else if (b >= utf8v_pkg::Lead3Lo && b <= utf8v_pkg::Lead3Hi) begin
      model_st.len_class = 2'd2;
      model_st.cp_acc    = utf8v_pkg::CpW'(b[3:0]);
    end else if (b >= utf8v_pkg::Lead4Lo && b <= utf8v_pkg::Lead4Hi) begin
      model_st.len_class = 2'd3;
      model_st.cp_acc    = utf8v_pkg::CpW'(b[2:0]);
    end else begin
      return utf8v_pkg::VERDICT_INVALID;
    end
    model_st.cont_left = model_st.len_class;
    return utf8v_pkg::VERDICT_PENDING;
  endfunction

  task automatic predict_verdict(logic [7:0] b, logic st);
    utf8v_pkg::verdict_e v;
    if (st) model_st = '0;
    if (model_st.reached) begin
      due_verdicts.push_back(verdict_rec_t'{utf8v_pkg::VERDICT_PENDING, 1'b0});
      return;
    end
    if (model_cfg.capacity == '0) begin
      v = utf8v_pkg::VERDICT_INVALID;
    end else begin
      v = judge_byte(b, model_st.bytes_taken == '0);
      if (model_st.bytes_taken != utf8v_pkg::BytesMax) model_st.bytes_taken++;
      if (v == utf8v_pkg::VERDICT_PENDING && model_st.bytes_taken >= model_cfg.capacity)
        v = utf8v_pkg::VERDICT_INVALID;
    end
    if (v != utf8v_pkg::VERDICT_PENDING) model_st.reached = 1'b1;
    due_verdicts.push_back(verdict_rec_t'{v, v != utf8v_pkg::VERDICT_PENDING});
  endtask

  task automatic report_mismatch(string what);
    if (mismatches < MaxShown) $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Driver: bursts with random gaps, hold a marked text until all results are back.
  always @(posedge clk_i or negedge rst_ni) begin : drv
    logic       took;
    text_item_t item;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      text_byte_i   <= 8'd0;
      starts_text_i <= 1'b0;
      bytes_sent    <= 0;
    end else begin
      took = in_valid_i && !in_stall_o;
      if (took) bytes_sent <= bytes_sent + 1;
      if (!in_valid_i || took) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (byte_feed.size() != 0 &&
                     !(byte_feed[0].hold && (took || results_seen != bytes_sent))) begin
          item = byte_feed.pop_front();
          in_valid_i    <= 1'b1;
          text_byte_i   <= item.data;
          starts_text_i <= item.start;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = bursty ? $urandom_range(1, 6) : 0;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check the result of this edge first, then predict the byte taken at it.
  always @(posedge clk_i or negedge rst_ni) begin : mon
    verdict_rec_t want;
    logic         stall_next;
    if (!rst_ni) begin
      out_stall_i  <= 1'b0;
      results_seen <= 0;
      model_cfg    = '{capacity: utf8v_pkg::CapacityReset, require_nonempty: 1'b1,
                       identifier_mode: 1'b0};
      model_st     = '0;
      model_st.reached = 1'b1;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (due_verdicts.size() == 0) begin
          report_mismatch("result with no byte outstanding");
        end else begin
          want = due_verdicts.pop_front();
          if (verdict_o !== want.verdict)
            report_mismatch($sformatf("verdict %0d, expected %0d", verdict_o, want.verdict));
          if (decided_o !== want.decided)
            report_mismatch($sformatf("decided %0b, expected %0b", decided_o, want.decided));
        end
      end
      if (in_valid_i && !in_stall_o) predict_verdict(text_byte_i, starts_text_i);

      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      stall_tick++;
      case (stall_mode)
        STALL_LIGHT:    stall_next = $urandom_range(0, 3) == 0;
        STALL_HEAVY:    stall_next = $urandom_range(0, 3) != 0;
        STALL_PERIODIC: stall_next = (stall_tick % 7) >= 3;
        default:        stall_next = 1'b0;
      endcase
      out_stall_i <= stall_next;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("** utf8_text_validator: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_byte(logic [7:0] b, logic st = 1'b0, bit hold = 1'b0);
    byte_feed.push_back(text_item_t'{b, st, hold});
    fed_total++;
  endtask

  task automatic add_text(bit id_style, int unsigned max_chars, bit hold);
    logic [7:0]                txt[$];
    logic [7:0]                seq[4];
    logic [utf8v_pkg::CpW-1:0] cp;
    int unsigned               n, r, cls, k;
    n = $urandom_range(0, max_chars);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (id_style) begin
        if (r < 92) txt.push_back(id_chars[$urandom_range(0, id_chars.len() - 1)]);
        else if (r < 97) txt.push_back(8'($urandom_range(32, 126)));
        else txt.push_back(8'($urandom_range(0, 255)));
      end else if (r < 45) begin
        txt.push_back(8'($urandom_range(32, 126)));
      end else if (r < 82) begin
        cls = $urandom_range(1, 3);
        if (r < 72 || r >= 77) begin
          case (cls)
            1: cp = utf8v_pkg::CpW'($urandom_range(utf8v_pkg::Min2Byte,
                                                   utf8v_pkg::Min3Byte - 1));
            2: begin
              cp = utf8v_pkg::CpW'($urandom_range(utf8v_pkg::Min3Byte,
                                                  utf8v_pkg::Min4Byte - 1));
              if (cp >= utf8v_pkg::SurLo && cp <= utf8v_pkg::SurHi) cp = cp - 21'h1000;
            end
            default: cp = utf8v_pkg::CpW'($urandom_range(utf8v_pkg::Min4Byte,
                                                         utf8v_pkg::CpMax));
          endcase
        end else begin
          case (cls)
            1: cp = utf8v_pkg::CpW'($urandom_range(0, utf8v_pkg::Min2Byte - 1));
            2: cp = utf8v_pkg::CpW'($urandom_range(0, 1) != 0
                        ? $urandom_range(0, utf8v_pkg::Min3Byte - 1)
                        : $urandom_range(utf8v_pkg::SurLo, utf8v_pkg::SurHi));
            default: cp = utf8v_pkg::CpW'($urandom_range(0, 1) != 0
                        ? $urandom_range(0, utf8v_pkg::Min4Byte - 1)
                        : $urandom_range(utf8v_pkg::CpMax + 1, {utf8v_pkg::CpW{1'b1}}));
          endcase
        end
        case (cls)
          1:       seq[0] = Lead2Mark | 8'(cp[10:6]);
          2:       seq[0] = utf8v_pkg::Lead3Lo | 8'(cp[15:12]);
          default: seq[0] = utf8v_pkg::Lead4Lo | 8'(cp[20:18]);
        endcase
        for (k = 1; k <= cls; k++) seq[k] = ContMark | 8'(cp[6*(cls-k) +: 6]);
        // corrupt or cut one continuation
        if (r >= 77) begin
          k = $urandom_range(1, cls);
          if ($urandom_range(0, 1) != 0) seq[k] = 8'($urandom_range(0, 255));
          else cls = k - 1;
        end
        for (k = 0; k <= cls; k++) txt.push_back(seq[k]);
      end else if (r < 87) begin
        txt.push_back(r < 85 ? 8'($urandom_range(1, 31)) : utf8v_pkg::DelByte);
      end else if (r < 93) begin
        txt.push_back($urandom_range(0, 1) != 0 ? 8'($urandom_range(8'h80, 8'hc1))
                                                : 8'($urandom_range(8'hf5, 8'hff)));
      end else begin
        txt.push_back(8'($urandom_range(0, 255)));
      end
    end
    r = $urandom_range(0, 99);
    if (r < 86 || txt.size() == 0) txt.push_back(NulByte);
    foreach (txt[i]) push_byte(txt[i], i == 0, hold && i == 0);
    if (r >= 90) repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic settle();
    while (results_seen != fed_total) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      utf8v_pkg::REG_TEXT_CAPACITY:    model_cfg.capacity = val;
      utf8v_pkg::REG_REQUIRE_NONEMPTY: model_cfg.require_nonempty = val[0];
      utf8v_pkg::REG_IDENTIFIER_MODE:  model_cfg.identifier_mode = val[0];
      default: ;
    endcase
  endtask

  task automatic write_regs(logic [15:0] cap, bit req, bit idm, bit poke);
    put_reg(utf8v_pkg::REG_TEXT_CAPACITY, cap);
    put_reg(utf8v_pkg::REG_REQUIRE_NONEMPTY, {15'($urandom), req});
    put_reg(utf8v_pkg::REG_IDENTIFIER_MODE, {15'($urandom), idm});
    if (poke) put_reg(RegUnused, 16'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(logic [15:0] cap, bit req, bit idm, bit poke,
                           int unsigned target, int unsigned max_chars);
    int unsigned goal, texts;
    settle();
    write_regs(cap, req, idm, poke);
    bursty = $urandom_range(0, 3) != 0;
    @(negedge clk_i);
    goal  = fed_total + target;
    texts = 0;
    while (fed_total < goal) begin
      add_text(idm ? $urandom_range(0, 9) != 0 : $urandom_range(0, 7) == 0, max_chars,
               texts == 5 || $urandom_range(0, 24) == 0);
      texts++;
    end
  endtask

  initial begin : stim
    logic [15:0] rcap;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset configuration: idle bytes, empty text, boundary sequences, bad leads, controls, cut sequences
    push_byte("A");
    push_byte(NulByte, 1'b1);
    push_byte("x");
    push_byte(8'hc2, 1'b1); push_byte(8'h80);
    push_byte(8'hf4); push_byte(8'h8f); push_byte(8'hbf); push_byte(8'hbf);
    push_byte(NulByte);
    push_byte(8'he0, 1'b1); push_byte(8'h9f); push_byte(8'h80);
    push_byte(8'hed, 1'b1); push_byte(8'ha0); push_byte(8'h80);
    push_byte(8'hff, 1'b1);
    push_byte(8'h1f, 1'b1);
    push_byte(utf8v_pkg::DelByte, 1'b1);
    push_byte(8'hc2, 1'b1); push_byte(NulByte);
    push_byte(8'he1, 1'b1);
    push_byte(8'h20, 1'b1); push_byte(NulByte);

    settle();
    write_regs(16'd0, 1'b0, 1'b1, 1'b0);
    @(negedge clk_i);
    push_byte("a", 1'b1);

    settle();
    write_regs(16'd3, 1'b0, 1'b1, 1'b1);
    @(negedge clk_i);
    push_byte(NulByte, 1'b1);
    push_byte("a", 1'b1); push_byte("b"); push_byte("c");
    push_byte(8'hc3, 1'b1);
    push_byte("#", 1'b1);

    settle();
    write_regs(16'd2, 1'b1, 1'b0, 1'b0);
    @(negedge clk_i);
    push_byte(8'he2, 1'b1); push_byte(8'h82);

    run_phase(16'd1, 1'b0, 1'b0, 1'b0, 120, 2);
    run_phase(16'hffff, 1'b1, 1'b0, 1'b1, 250, 24);
    run_phase(16'd3, 1'b1, 1'b0, 1'b0, 150, 5);
    run_phase(utf8v_pkg::CapacityReset, 1'b0, 1'b1, 1'b0, 200, 70);
    run_phase(16'd8, 1'b1, 1'b1, 1'b1, 150, 10);
    run_phase(16'd0, 1'b0, 1'b0, 1'b0, 30, 4);
    repeat (4) begin
      case ($urandom_range(0, 5))
        0:       rcap = 16'd1;
        1:       rcap = 16'hffff;
        2:       rcap = utf8v_pkg::CapacityReset;
        default: rcap = 16'($urandom_range(2, 20));
      endcase
      run_phase(rcap, $urandom_range(0, 1) != 0, $urandom_range(0, 2) == 0,
                $urandom_range(0, 1) != 0, 240, rcap <= 16'd20 ? rcap + 3 : 30);
    end

    settle();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && due_verdicts.size() == 0) begin
      $display("** utf8_text_validator: PASSED **");
    end else begin
      $display("** utf8_text_validator: FAILED **");
    end
    $finish;
  end

endmodule
